[src/triangle_scanline_fill_top_defines.svh]
// Assertion macros shared by the block's modules.
`ifndef TRIANGLE_SCANLINE_FILL_TOP_DEFINES_SVH
`define TRIANGLE_SCANLINE_FILL_TOP_DEFINES_SVH

// Asserts that a condition implies a consequence in the same cycle.
`define TSF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Asserts that a condition implies a consequence in the next cycle.
`define TSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tsf_pkg.sv]
package tsf_pkg;

    localparam int SCREEN_W = 128;
    localparam int SCREEN_H = 64;
    localparam int XW = 7;
    localparam int YW = 6;
    localparam int OW = 8;
    localparam int QW = 14;
    localparam int DIV_STEPS = QW;
    localparam logic [1:0] MAIN_BUF_COLOR = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SIDE,
        ST_DIV_L,
        ST_DIV_R,
        ST_EMIT
    } state_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;
        logic sort;
        logic side;
        logic div_start;
        logic div_right;
        logic emit;
        logic next_row;
    } cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic last_row;
        logic out_full;
    } stat_t;

endpackage

[src/tsf_div.sv]
`include "triangle_scanline_fill_top_defines.svh"

// Restoring divider of an unsigned 14-bit dividend by a 6-bit divisor,
// one quotient bit per cycle.
module tsf_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tsf_pkg::QW-1:0]    dividend,
    input  logic [tsf_pkg::YW-1:0]    divisor,
    output logic                      busy,
    output logic                      done,
    output logic [tsf_pkg::QW-1:0]    quotient,
    output logic [tsf_pkg::YW-1:0]    remainder
);
    import tsf_pkg::*;

    logic [QW-1:0] q_reg, q_next;
    logic [YW-1:0] r_reg, r_next;
    logic [YW-1:0] d_reg, d_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [YW:0]   trial;

    // Load on start, else one shift and subtract step while busy.
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[QW-1]};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 4'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = YW'(trial - {1'b0, d_reg});
                q_next = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[YW-1:0];
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = q_reg;
    assign remainder = r_reg;

    `TSF_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_reg, !busy_reg, "done while busy")
    `TSF_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_reg, "start did not set busy")
    `TSF_ASSERT_IMP(a_cnt_busy, clk, rst_n, busy_reg, cnt_reg != 4'd0, "busy with zero count")

endmodule

[src/tsf_datapath.sv]
`include "triangle_scanline_fill_top_defines.svh"

// Vertex registers, side decision, edge interpolation and output register.
module tsf_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsf_pkg::cmd_t         cmd,
    output tsf_pkg::stat_t        stat,
    input  logic [40:0]           in_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);
    import tsf_pkg::*;

    logic [XW-1:0] x0_reg, x1_reg, x2_reg, x0_next, x1_next, x2_next;
    logic [YW-1:0] y0_reg, y1_reg, y2_reg, y0_next, y1_next, y2_next;
    logic [1:0]    col_reg;
    logic          left_reg;
    logic [YW-1:0] row_reg;
    logic [OW-1:0] s_reg;
    logic          ov_reg;
    logic [23:0]   od_reg;
    logic          og_reg;
    logic          ol_reg;

    logic [XW-1:0] ax_e, bx_e;
    logic [YW-1:0] ay_e, by_e;
    logic [YW-1:0] dy_e, n_e;
    logic signed [XW:0] dx_e;
    logic [QW-1:0] mag_e;
    logic          neg_e, endp_b, endp_a;
    logic [QW-1:0] quo;
    logic [YW-1:0] rem;
    logic          dbusy, ddone;
    logic signed [QW+1:0] qs;
    logic signed [QW+1:0] xv;
    logic [OW-1:0] xc, e_fin;
    logic signed [XW+YW+1:0] c1, c2;

    // Vertex load, or bubble sort of three vertices, stable on equal y.
    always_comb
    begin
        logic [XW-1:0] tx;
        logic [YW-1:0] ty;
        tx = '0;
        ty = '0;
        x0_next = x0_reg; y0_next = y0_reg;
        x1_next = x1_reg; y1_next = y1_reg;
        x2_next = x2_reg; y2_next = y2_reg;
        if (cmd.load)
        begin
            x0_next = in_tdata[6:0];   y0_next = in_tdata[12:7];
            x1_next = in_tdata[19:13]; y1_next = in_tdata[25:20];
            x2_next = in_tdata[32:26]; y2_next = in_tdata[38:33];
        end
        else if (cmd.sort)
        begin
            if (y0_next > y1_next)
            begin
                tx = x0_next; ty = y0_next;
                x0_next = x1_next; y0_next = y1_next; x1_next = tx; y1_next = ty;
            end
            if (y1_next > y2_next)
            begin
                tx = x1_next; ty = y1_next;
                x1_next = x2_next; y1_next = y2_next; x2_next = tx; y2_next = ty;
            end
            if (y0_next > y1_next)
            begin
                tx = x0_next; ty = y0_next;
                x0_next = x1_next; y0_next = y1_next; x1_next = tx; y1_next = ty;
            end
        end
    end

    // Cross-multiplied slope products.
    assign c1 = (XW+YW+2)'($signed({1'b0, x1_reg}) - $signed({1'b0, x0_reg}))
              * $signed({1'b0, y2_reg - y0_reg});
    assign c2 = (XW+YW+2)'($signed({1'b0, x2_reg}) - $signed({1'b0, x0_reg}))
              * $signed({1'b0, y1_reg - y0_reg});

    // Edge endpoints for the current row and side.
    always_comb
    begin
        logic use_long;
        use_long = (cmd.div_right != left_reg);
        if (use_long)
        begin
            ax_e = x0_reg; ay_e = y0_reg; bx_e = x2_reg; by_e = y2_reg;
        end
        else if (row_reg < y1_reg)
        begin
            ax_e = x0_reg; ay_e = y0_reg; bx_e = x1_reg; by_e = y1_reg;
        end
        else
        begin
            ax_e = x1_reg; ay_e = y1_reg; bx_e = x2_reg; by_e = y2_reg;
        end
        dy_e = by_e - ay_e;
        n_e = row_reg - ay_e;
        dx_e = $signed({1'b0, bx_e}) - $signed({1'b0, ax_e});
        endp_b = (by_e <= ay_e) || (row_reg >= by_e);
        endp_a = (row_reg <= ay_e);
        neg_e = dx_e[XW];
        mag_e = QW'(neg_e ? -dx_e : dx_e) * QW'(n_e);
    end

    tsf_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (mag_e),
        .divisor   (endp_b || endp_a ? YW'(1) : dy_e),
        .busy      (dbusy),
        .done      (ddone),
        .quotient  (quo),
        .remainder (rem)
    );

    // Floor of the signed quotient, added to the start x, clipped.
    always_comb
    begin
        qs = '0;
        if (endp_b)
            xv = (QW+2)'(bx_e);
        else if (endp_a)
            xv = (QW+2)'(ax_e);
        else
        begin
            qs = neg_e ? -$signed({2'b00, quo}) - $signed((QW+2)'(rem != '0))
                       : $signed({2'b00, quo});
            xv = $signed((QW+2)'(ax_e)) + qs;
        end
        if (xv < 0)
            xc = '0;
        else if (xv > SCREEN_W)
            xc = OW'(SCREEN_W);
        else
            xc = xv[OW-1:0];
        e_fin = (xc < s_reg || (YW+1)'(row_reg) >= (YW+1)'(SCREEN_H)) ? s_reg : xc;
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= x0_next; y0_reg <= y0_next;
        x1_reg <= x1_next; y1_reg <= y1_next;
        x2_reg <= x2_next; y2_reg <= y2_next;
        if (cmd.load)
            col_reg <= in_tdata[40:39];
        if (cmd.side)
        begin
            if (y1_reg != y0_reg && y2_reg != y0_reg)
                left_reg <= c1 > c2;
            else if (y2_reg != y0_reg)
                left_reg <= x2_reg < x0_reg;
            else
                left_reg <= 1'b0;
            row_reg <= y0_reg;
        end
        else if (cmd.next_row)
            row_reg <= row_reg + YW'(1);
        if (ddone && !cmd.div_right)
            s_reg <= xc;
        if (cmd.emit)
        begin
            od_reg <= {col_reg, e_fin, s_reg, row_reg};
            og_reg <= (col_reg != MAIN_BUF_COLOR);
            ol_reg <= (row_reg == y2_reg);
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.emit)
            ov_reg <= 1'b1;
        else if (m_tready)
            ov_reg <= 1'b0;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = od_reg;
    assign m_tuser = og_reg;
    assign m_tlast = ol_reg;
    assign stat.div_busy = dbusy;
    assign stat.div_done = ddone;
    assign stat.last_row = (row_reg == y2_reg);
    assign stat.out_full = ov_reg && !m_tready;

    `TSF_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, ov_reg, "emit lost")
    `TSF_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !(ov_reg && !m_tready), "overwrite")
    `TSF_ASSERT_IMP(a_row_range, clk, rst_n, ov_reg, od_reg[21:14] >= od_reg[13:6], "end < start")

endmodule

[src/tsf_ctrl.sv]
`include "triangle_scanline_fill_top_defines.svh"

// Sequencer: sort, side decision, two divisions and one emit per row.
module tsf_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output tsf_pkg::cmd_t   cmd,
    input  tsf_pkg::stat_t  stat
);
    import tsf_pkg::*;

    state_t state_reg, state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SORT;
            ST_SORT:  state_next = ST_SIDE;
            ST_SIDE:  state_next = ST_DIV_L;
            ST_DIV_L: if (stat.div_done) state_next = ST_DIV_R;
            ST_DIV_R: if (stat.div_done) state_next = ST_EMIT;
            ST_EMIT:
                if (!stat.out_full)
                    state_next = stat.last_row ? ST_IDLE : ST_DIV_L;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SORT:  cmd.sort = 1'b1;
            ST_SIDE:  cmd.side = 1'b1;
            ST_DIV_L:
                cmd.div_start = !stat.div_busy && !stat.div_done;
            ST_DIV_R:
            begin
                cmd.div_right = 1'b1;
                cmd.div_start = !stat.div_busy && !stat.div_done;
            end
            ST_EMIT:
            begin
                cmd.div_right = 1'b1;
                cmd.emit = !stat.out_full;
                cmd.next_row = !stat.out_full && !stat.last_row;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `TSF_ASSERT_IMP(a_ready_idle, clk, rst_n, s_tready, state_reg == ST_IDLE, "ready busy")
    `TSF_ASSERT_IMP(a_emit_state, clk, rst_n, cmd.emit, state_reg == ST_EMIT, "stray emit")
    `TSF_ASSERT_NEXT(a_load_sort, clk, rst_n, cmd.load, state_reg == ST_SORT, "no sort")

endmodule

[src/triangle_scanline_fill_top.sv]
// Scanline triangle fill. Each accepted triangle yields one span per row from its top
// vertex to its bottom vertex; tlast marks the bottom row and tuser selects the gray
// buffer. A row takes two passes of one shared 14-step divider, one per edge, and one
// emit, which waits while the output stalls. A triangle is accepted, sorted and given
// its side decision before its rows, up to 64 of them, and the next triangle is taken
// only after the last span has been registered for output.
module triangle_scanline_fill_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ax, ay, bx, by_, cx, cy, fill_color, zero padding
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // row, span_start, span_end, span_color
    output logic [23:0] m_tdata,
    // gray_target
    output logic        m_tuser,
    output logic        m_tlast
);
    import tsf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tsf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    tsf_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_tdata (s_tdata[40:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[sim/tb_triangle_scanline_fill_top.sv]
`timescale 1ns / 100ps

module tb_triangle_scanline_fill_top;
    import tsf_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD = 600;

    typedef struct {
        logic [6:0] ax;
        logic [5:0] ay;
        logic [6:0] bx;
        logic [5:0] by_;
        logic [6:0] cx;
        logic [5:0] cy;
        logic [1:0] fill_color;
        bit         drain_first;
    } triangle_t;

    typedef struct {
        logic [5:0] row;
        logic [7:0] span_start;
        logic [7:0] span_end;
        logic       gray_target;
        logic [1:0] span_color;
        logic       last_span;
    } span_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    triangle_t   pending_tris[$];
    span_t       expected_spans[$];
    bit          tri_taken;
    int          gap_left;
    int          burst_left;
    int          stall_left;
    int          hold_left;
    bit          long_hold_done;
    int          idle_cycles;
    int          errors;
    int          tris_sent;
    int          spans_seen;
    bit          stimulus_done;

    triangle_scanline_fill_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Floored x of an edge at a row, with the row's fraction along the edge clamped to [0,1].
    function automatic int edge_x_at(int r, int xa, int ya, int xb, int yb);
        int d;
        int n;
        int t;
        int q;
        d = yb - ya;
        n = r - ya;
        if (d <= 0 || n >= d)
            return xb;
        if (n <= 0)
            return xa;
        t = (xb - xa) * n;
        if (t >= 0)
            q = t / d;
        else
            q = -((-t + d - 1) / d);
        return xa + q;
    endfunction

    function automatic int clip_x(int x);
        if (x < 0)
            return 0;
        if (x > SCREEN_W)
            return SCREEN_W;
        return x;
    endfunction

    // Sorts the vertices, picks the long side and queues one span per row.
    function automatic void rasterize(triangle_t t);
        int    x0, y0, x1, y1, x2, y2, tx, ty;
        int    lxa, lya, lxb, lyb, rxa, rya, rxb, ryb;
        int    s, e, r, cnt;
        bit    long_left;
        span_t sp;
        x0 = int'(t.ax); y0 = int'(t.ay); x1 = int'(t.bx); y1 = int'(t.by_);
        x2 = int'(t.cx); y2 = int'(t.cy);
        if (y0 > y1)
        begin
            tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty;
        end
        if (y1 > y2)
        begin
            tx = x1; ty = y1; x1 = x2; y1 = y2; x2 = tx; y2 = ty;
        end
        if (y0 > y1)
        begin
            tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty;
        end
        if (y1 - y0 > 0 && y2 - y0 > 0)
            long_left = (x1 - x0) * (y2 - y0) > (x2 - x0) * (y1 - y0);
        else if (y2 - y0 > 0)
            long_left = (x2 - x0) < 0;
        else
            long_left = 1'b0;
        cnt = 0;
        for (r = y0; r <= y2 && cnt < 64; r++)
        begin
            if (long_left)
            begin
                lxa = x0; lya = y0; lxb = x2; lyb = y2;
                if (r < y1)
                begin
                    rxa = x0; rya = y0; rxb = x1; ryb = y1;
                end
                else
                begin
                    rxa = x1; rya = y1; rxb = x2; ryb = y2;
                end
            end
            else
            begin
                rxa = x0; rya = y0; rxb = x2; ryb = y2;
                if (r < y1)
                begin
                    lxa = x0; lya = y0; lxb = x1; lyb = y1;
                end
                else
                begin
                    lxa = x1; lya = y1; lxb = x2; lyb = y2;
                end
            end
            s = clip_x(edge_x_at(r, lxa, lya, lxb, lyb));
            e = clip_x(edge_x_at(r, rxa, rya, rxb, ryb));
            if (e < s || r >= SCREEN_H)
                e = s;
            sp.row = r[5:0];
            sp.span_start = s[7:0];
            sp.span_end = e[7:0];
            sp.gray_target = (t.fill_color != MAIN_BUF_COLOR);
            sp.span_color = t.fill_color;
            sp.last_span = (r == y2);
            expected_spans.push_back(sp);
            cnt++;
        end
    endfunction

    function automatic triangle_t make_tri(int ax, int ay, int bx, int by_, int cx, int cy,
                                           int col);
        triangle_t t;
        t.ax = 7'(ax); t.ay = 6'(ay); t.bx = 7'(bx); t.by_ = 6'(by_);
        t.cx = 7'(cx); t.cy = 6'(cy);
        t.fill_color = 2'(col);
        t.drain_first = 1'b0;
        return t;
    endfunction

    // Stimulus: directed corner cases, then random triangles.
    initial
    begin
        triangle_t t;
        int        base_y;
        int        ext;
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0));
        pending_tris.push_back(make_tri(127, 63, 127, 63, 127, 63, 3));
        pending_tris.push_back(make_tri(10, 5, 90, 5, 50, 5, 1));
        pending_tris.push_back(make_tri(0, 0, 127, 0, 64, 63, 2));
        pending_tris.push_back(make_tri(64, 0, 0, 63, 127, 63, 3));
        pending_tris.push_back(make_tri(0, 0, 127, 30, 0, 63, 0));
        pending_tris.push_back(make_tri(127, 0, 0, 30, 127, 63, 1));
        pending_tris.push_back(make_tri(20, 10, 100, 10, 60, 40, 2));
        pending_tris.push_back(make_tri(60, 40, 20, 10, 100, 10, 3));
        pending_tris.push_back(make_tri(50, 20, 50, 20, 90, 50, 0));
        pending_tris.push_back(make_tri(30, 50, 80, 8, 5, 8, 1));
        pending_tris.push_back(make_tri(127, 0, 127, 63, 0, 63, 2));
        pending_tris.push_back(make_tri(0, 63, 127, 0, 127, 63, 3));
        pending_tris.push_back(make_tri(40, 3, 41, 60, 39, 30, 0));
        pending_tris.push_back(make_tri(85, 42, 42, 21, 21, 63, 1));
        pending_tris.push_back(make_tri(7, 1, 120, 2, 64, 3, 2));
        pending_tris.push_back(make_tri(64, 32, 64, 0, 64, 63, 3));
        pending_tris.push_back(make_tri(127, 1, 1, 62, 126, 63, 0));
        pending_tris.push_back(make_tri(85, 21, 42, 42, 21, 42, 2));
        for (int i = 0; i < 455; i++)
        begin
            // Mostly short triangles; a few may span up to the full screen height.
            if ($urandom_range(0, 9) == 0)
                ext = 63;
            else
                ext = $urandom_range(0, 12);
            base_y = $urandom_range(0, 63 - ext);
            t.ax = 7'($urandom_range(0, 127));
            t.bx = 7'($urandom_range(0, 127));
            t.cx = 7'($urandom_range(0, 127));
            t.ay = 6'(base_y + $urandom_range(0, ext));
            t.by_ = 6'(base_y + $urandom_range(0, ext));
            t.cy = 6'(base_y + $urandom_range(0, ext));
            if ($urandom_range(0, 7) == 0)
                t.by_ = t.ay;
            t.fill_color = 2'($urandom_range(0, 3));
            t.drain_first = (i == 200);
            pending_tris.push_back(t);
        end
    end

    // Driver: bursts of triangles with random gaps, changes at the falling edge.
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !tri_taken)
            begin
                // Hold the current transaction until it is accepted.
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_tris.size() == 0)
            begin
                s_tvalid <= 1'b0;
            end
            else if (pending_tris[0].drain_first && expected_spans.size() != 0)
            begin
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tdata <= {7'd0, pending_tris[0].fill_color, pending_tris[0].cy,
                            pending_tris[0].cx, pending_tris[0].by_, pending_tris[0].bx,
                            pending_tris[0].ay, pending_tris[0].ax};
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left <= burst_left - 1;
                end
                else
                begin
                    burst_left <= $urandom_range(0, 6);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
    end

    // Receiver: random stalls, stall-free stretches and one long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (!long_hold_done && tris_sent == 60)
            begin
                long_hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ((tris_sent / 40) % 2 == 1 && $urandom_range(0, 4) == 0)
                    stall_left <= $urandom_range(1, 8);
            end
        end
    end

    // Input acceptance, prediction, output checking and the watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        span_t got;
        span_t want;
        if (!rst_n)
        begin
            tri_taken <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            tri_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                rasterize(pending_tris[0]);
                pending_tris.pop_front();
                tris_sent <= tris_sent + 1;
            end
            if (m_tvalid && m_tready)
            begin
                spans_seen <= spans_seen + 1;
                got.row = m_tdata[5:0];
                got.span_start = m_tdata[13:6];
                got.span_end = m_tdata[21:14];
                got.span_color = m_tdata[23:22];
                got.gray_target = m_tuser;
                got.last_span = m_tlast;
                if (expected_spans.size() == 0)
                begin
                    errors <= errors + 1;
                    $display("%0t: unexpected span row=%0d start=%0d end=%0d", $time,
                             got.row, got.span_start, got.span_end);
                end
                else
                begin
                    want = expected_spans.pop_front();
                    if (got.row !== want.row || got.span_start !== want.span_start ||
                        got.span_end !== want.span_end || got.span_color !== want.span_color ||
                        got.gray_target !== want.gray_target ||
                        got.last_span !== want.last_span)
                    begin
                        errors <= errors + 1;
                        $display({"%0t: span mismatch expected row=%0d start=%0d end=%0d",
                                  " gray=%0d color=%0d last=%0d"},
                                 $time, want.row, want.span_start, want.span_end,
                                 want.gray_target, want.span_color, want.last_span);
                        $display({"%0t:                 actual row=%0d start=%0d end=%0d",
                                  " gray=%0d color=%0d last=%0d"},
                                 $time, got.row, got.span_start, got.span_end,
                                 got.gray_target, got.span_color, got.last_span);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || stimulus_done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // End of run: wait for all spans, let the block settle, then report.
    initial
    begin
        errors = 0;
        tris_sent = 0;
        spans_seen = 0;
        gap_left = 0;
        burst_left = 0;
        stall_left = 0;
        hold_left = 0;
        long_hold_done = 1'b0;
        stimulus_done = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        while (pending_tris.size() != 0 || s_tvalid || expected_spans.size() != 0)
            @(posedge clk);
        stimulus_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d triangles (directed corners, flat and tied edges, random sizes).",
                 tris_sent);
        $display("Checked %0d spans under random back-pressure and one long output hold.",
                 spans_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/tsf_pkg.sv
src/tsf_div.sv
src/tsf_datapath.sv
src/tsf_ctrl.sv
src/triangle_scanline_fill_top.sv
sim/tb_triangle_scanline_fill_top.sv
